/* hdl/cbi_pkg.sv */
// Shared types for the clamped barycentric interpolator.
// Region codes, corner selectors and the sideband carried through the divider.
// No dependencies.
package cbi_pkg;

   localparam int NUM_CORNERS = 3;

   // Region reported with each result
   typedef enum logic [1:0] {
      REGION_INSIDE = 2'd0,
      REGION_EDGE   = 2'd1,
      REGION_CORNER = 2'd2,
      REGION_FAULT  = 2'd3
   } region_type;

   // Triangle corner selector
   typedef enum logic [1:0] {
      CORNER_A = 2'd0,
      CORNER_B = 2'd1,
      CORNER_C = 2'd2
   } corner_type;

   // Sign and region that ride along with the quotient
   typedef struct packed {
      logic       neg;
      region_type region;
   } side_type;

endpackage

/* hdl/clamped_barycentric_interp.sv */
// From an accepted transaction to rsp_tvalid a result passes the input, product, sum and
// magnitude registers, the restoring divider with one quotient bit per stage and the output
// register. Throughput: one transaction per cycle while the skid entry is empty. An output
// register plus one skid entry keep req_tready high while one finished result waits for
// rsp_tready. Reset (synchronous, active high) empties the pipeline and sets clamp_ff to 1.
// Depends on cbi_pkg and cbi_divider.
module clamped_barycentric_interp
   import cbi_pkg::*;
#(
   parameter int WEIGHT_WIDTH  = 16,
   parameter int FRACTION_BITS = 12,
   parameter int VALUE_WIDTH   = 24
) (
   input  logic clock,
   input  logic reset,
   // weight_a, weight_b, weight_c, value_a, value_b, value_c from bit 0 up
   input  logic [((3*(WEIGHT_WIDTH+VALUE_WIDTH)+7)/8)*8-1:0] req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // result_value from bit 0 up
   output logic [((VALUE_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // region, saturated from bit 0 up
   output logic [2:0] rsp_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic csr_wr_en,
   input  logic csr_wr_data
);

   localparam int WW     = WEIGHT_WIDTH;
   localparam int VW     = VALUE_WIDTH;
   localparam int FB     = FRACTION_BITS;
   localparam int PW     = WW + VW;
   localparam int SW     = PW + 2;
   localparam int MW     = PW + 1;
   localparam int DW     = (WW > FB + 1) ? WW : FB + 1;
   localparam int XW     = ((MW > DW) ? MW : DW) + 2;
   localparam int YW     = DW + 1;
   localparam int QW     = VW + 1;
   localparam int OUT_TW = ((VW + 7) / 8) * 8;
   localparam int RES_W  = VW + 3;

   localparam logic [QW-1:0] POS_LIM = {2'b00, {(VW-1){1'b1}}};
   localparam logic [QW-1:0] NEG_LIM = {2'b01, {(VW-1){1'b0}}};

   logic en;
   logic clamp_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_ff <= 1'b1;
      end else if (csr_wr_en) begin
         clamp_ff <= csr_wr_data;
      end
   end

   // ---------------- stage 1: input register ----------------
   logic                 s1_vld_ff;
   logic signed [WW-1:0] w_ff [NUM_CORNERS];
   logic signed [VW-1:0] v_ff [NUM_CORNERS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_CORNERS; i++) begin
            w_ff[i] <= req_tdata[i*WW +: WW];
            v_ff[i] <= req_tdata[NUM_CORNERS*WW + i*VW +: VW];
         end
      end
   end

   // ---------------- stage 2: products and classification ----------------
   logic signed [PW-1:0] prod_in [NUM_CORNERS];
   logic signed [WW-1:0] w_lo, w_hi;
   logic [1:0]           neg_cnt;
   corner_type           mini_in, maxi_in;
   region_type           rgn2_in;
   logic [WW-1:0]        dedge_in;
   logic signed [VW-1:0] cval_in;

   always_comb begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
         prod_in[i] = PW'(w_ff[i]) * PW'(v_ff[i]);
      end
      neg_cnt = 2'(w_ff[0][WW-1]) + 2'(w_ff[1][WW-1]) + 2'(w_ff[2][WW-1]);

      // smallest weight, first index on ties
      mini_in = (w_ff[1] < w_ff[0]) ? CORNER_B : CORNER_A;
      w_lo    = (w_ff[1] < w_ff[0]) ? w_ff[1] : w_ff[0];
      if (w_ff[2] < w_lo) begin
         mini_in = CORNER_C;
      end

      // largest weight, first index on ties
      maxi_in = (w_ff[1] > w_ff[0]) ? CORNER_B : CORNER_A;
      w_hi    = (w_ff[1] > w_ff[0]) ? w_ff[1] : w_ff[0];
      if (w_ff[2] > w_hi) begin
         maxi_in = CORNER_C;
      end

      // sum of the two weights opposite the smallest one
      case (mini_in)
         CORNER_A: dedge_in = $unsigned(w_ff[1]) + $unsigned(w_ff[2]);
         CORNER_B: dedge_in = $unsigned(w_ff[0]) + $unsigned(w_ff[2]);
         default:  dedge_in = $unsigned(w_ff[0]) + $unsigned(w_ff[1]);
      endcase

      case (maxi_in)
         CORNER_A: cval_in = v_ff[0];
         CORNER_B: cval_in = v_ff[1];
         default:  cval_in = v_ff[2];
      endcase

      if (!clamp_ff || neg_cnt == 2'd0) begin
         rgn2_in = REGION_INSIDE;
      end else if (neg_cnt == 2'd1) begin
         rgn2_in = REGION_EDGE;
      end else begin
         rgn2_in = REGION_CORNER;
      end
   end

   logic                 s2_vld_ff;
   logic signed [PW-1:0] prod_ff [NUM_CORNERS];
   corner_type           mini_ff;
   region_type           rgn2_ff;
   logic [WW-1:0]        dedge_ff;
   logic signed [VW-1:0] cval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         mini_ff  <= mini_in;
         rgn2_ff  <= rgn2_in;
         dedge_ff <= dedge_in;
         cval_ff  <= cval_in;
      end
   end

   // ---------------- stage 3: sums and numerator/denominator select ----------------
   // plain sum divides by 2^FB, edge by the edge weight sum, corner and fault by 1
   logic signed [SW-1:0] sum_all, sum_pair, val_in;
   logic [DW-1:0]        d_in;
   region_type           rgn3_in;

   always_comb begin
      sum_all = SW'(prod_ff[0]) + SW'(prod_ff[1]) + SW'(prod_ff[2]);
      case (mini_ff)
         CORNER_A: sum_pair = SW'(prod_ff[1]) + SW'(prod_ff[2]);
         CORNER_B: sum_pair = SW'(prod_ff[0]) + SW'(prod_ff[2]);
         default:  sum_pair = SW'(prod_ff[0]) + SW'(prod_ff[1]);
      endcase

      val_in  = '0;
      d_in    = DW'(1);
      rgn3_in = REGION_FAULT;
      case (rgn2_ff)
         REGION_INSIDE: begin
            val_in     = sum_all;
            d_in       = '0;
            d_in[FB]   = 1'b1;
            rgn3_in    = REGION_INSIDE;
         end
         REGION_EDGE: begin
            if (dedge_ff != '0) begin
               val_in  = sum_pair;
               d_in    = DW'(dedge_ff);
               rgn3_in = REGION_EDGE;
            end
         end
         REGION_CORNER: begin
            val_in  = SW'(cval_ff);
            rgn3_in = REGION_CORNER;
         end
         default: begin
            rgn3_in = REGION_FAULT;
         end
      endcase
   end

   logic                 s3_vld_ff;
   logic signed [SW-1:0] val_ff;
   logic [DW-1:0]        d_ff;
   region_type           rgn3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         val_ff  <= val_in;
         d_ff    <= d_in;
         rgn3_ff <= rgn3_in;
      end
   end

   // ---------------- stage 4: magnitude and rounding offset ----------------
   // round half away from zero: q = (2|n| + d) / (2d)
   logic [SW-1:0] abs_v;
   logic [XW-1:0] x_in;
   logic [YW-1:0] y_in;
   side_type      side_in;

   always_comb begin
      abs_v          = val_ff[SW-1] ? $unsigned(-val_ff) : $unsigned(val_ff);
      x_in           = (XW'(abs_v[MW-1:0]) << 1) + XW'(d_ff);
      y_in           = {d_ff, 1'b0};
      side_in.neg    = val_ff[SW-1];
      side_in.region = rgn3_ff;
   end

   logic          s4_vld_ff;
   logic [XW-1:0] x_ff;
   logic [YW-1:0] y_ff;
   side_type      side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         side_ff <= side_in;
      end
   end

   // ---------------- divider ----------------
   logic          fin_vld;
   logic [QW-1:0] fin_q;
   logic          fin_ovf;
   side_type      fin_side;

   cbi_divider #(
      .XW (XW),
      .YW (YW),
      .QW (QW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_vld_ff),
      .in_x      (x_ff),
      .in_y      (y_ff),
      .in_side   (side_ff),
      .out_valid (fin_vld),
      .out_q     (fin_q),
      .out_ovf   (fin_ovf),
      .out_side  (fin_side)
   );

   // ---------------- saturation ----------------
   logic             fin_sat;
   logic [QW-1:0]    fin_mag;
   logic [QW-1:0]    fin_bits;
   logic [RES_W-1:0] fin_res;

   always_comb begin
      if (fin_side.neg) begin
         fin_sat  = fin_ovf || (fin_q > NEG_LIM);
         fin_mag  = fin_sat ? NEG_LIM : fin_q;
         fin_bits = QW'(0) - fin_mag;
      end else begin
         fin_sat  = fin_ovf || (fin_q > POS_LIM);
         fin_mag  = fin_sat ? POS_LIM : fin_q;
         fin_bits = fin_mag;
      end
      fin_res = {fin_sat, fin_side.region, fin_bits[VW-1:0]};
   end

   // ---------------- output register and skid entry ----------------
   logic             rsp_vld_ff, rsp_vld_in;
   logic             skid_vld_ff, skid_vld_in;
   logic [RES_W-1:0] rsp_res_ff, rsp_res_in;
   logic [RES_W-1:0] skid_res_ff, skid_res_in;
   logic             out_load;

   always_comb begin
      out_load    = !rsp_vld_ff || rsp_tready;
      rsp_vld_in  = rsp_vld_ff;
      rsp_res_in  = rsp_res_ff;
      skid_vld_in = skid_vld_ff;
      skid_res_in = skid_res_ff;
      if (out_load) begin
         if (skid_vld_ff) begin
            rsp_vld_in  = 1'b1;
            rsp_res_in  = skid_res_ff;
            skid_vld_in = 1'b0;
         end else begin
            rsp_vld_in  = fin_vld;
            rsp_res_in  = fin_res;
         end
      end else if (fin_vld && !skid_vld_ff) begin
         skid_vld_in = 1'b1;
         skid_res_in = fin_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff  <= rsp_res_in;
      skid_res_ff <= skid_res_in;
   end

   // pipeline moves whenever the skid entry is free
   assign en         = !skid_vld_ff;
   assign req_tready = en;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = OUT_TW'(rsp_res_ff[VW-1:0]);
   assign rsp_tuser  = rsp_res_ff[RES_W-1:VW];

endmodule

/* hdl/cbi_divider.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Entry stage flags quotients that do not fit in QW bits.
// Depends on cbi_pkg for the sideband type.
module cbi_divider
   import cbi_pkg::*;
#(
   parameter int XW = 45,
   parameter int YW = 18,
   parameter int QW = 25
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [XW-1:0] in_x,
   input  logic [YW-1:0] in_y,
   input  side_type      in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_q,
   output logic          out_ovf,
   output side_type      out_side
);

   localparam int RW = (XW > YW + QW) ? XW : YW + QW;

   logic [QW:0]   vld_ff;
   logic [QW:0]   ovf_ff;
   logic [RW-1:0] rem_ff  [QW+1];
   logic [YW-1:0] y_ff    [QW+1];
   logic [QW-1:0] q_ff    [QW+1];
   side_type      side_ff [QW+1];

   logic [RW-1:0] dsr     [QW];
   logic [QW-1:0] ge;

   // trial subtract per stage, stage k resolves quotient bit QW-1-k
   always_comb begin
      for (int k = 0; k < QW; k++) begin
         dsr[k] = RW'(y_ff[k]) << (QW - 1 - k);
         ge[k]  = rem_ff[k] >= dsr[k];
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[QW-1:0], in_valid};
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= RW'(in_x);
         y_ff[0]    <= in_y;
         q_ff[0]    <= '0;
         ovf_ff[0]  <= RW'(in_x) >= (RW'(in_y) << QW);
         side_ff[0] <= in_side;
         for (int k = 0; k < QW; k++) begin
            rem_ff[k+1]  <= ge[k] ? rem_ff[k] - dsr[k] : rem_ff[k];
            y_ff[k+1]    <= y_ff[k];
            q_ff[k+1]    <= {q_ff[k][QW-2:0], ge[k]};
            ovf_ff[k+1]  <= ovf_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_q     = q_ff[QW];
   assign out_ovf   = ovf_ff[QW];
   assign out_side  = side_ff[QW];

endmodule

/* hdl/cbi_checker.sv */
// Port-level checks for clamped_barycentric_interp, attached by bind.
// Depends on cbi_pkg for the region codes.
module cbi_checker
   import cbi_pkg::*;
#(
   parameter int VALUE_WIDTH = 24
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [((VALUE_WIDTH+7)/8)*8-1:0]     rsp_tdata,
   input logic [2:0]                           rsp_tuser
);

   localparam int VW = VALUE_WIDTH;

   logic [VW-1:0] res;
   logic [1:0]    rgn;
   logic          sat;

   assign res = rsp_tdata[VW-1:0];
   assign rgn = rsp_tuser[1:0];
   assign sat = rsp_tuser[2];

   // reset leaves an empty pipeline that takes input
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   // a stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // zero edge weight sum reports zero, unclipped
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rgn == REGION_FAULT |-> res == '0 && !sat)
      else $error("fault result not zero");

   // corner values pass unchanged, so they are never flagged saturated
   a_corner_nosat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rgn == REGION_CORNER |-> !sat)
      else $error("corner result flagged saturated");

   // clipped results sit at a range limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && sat |->
         res == {1'b0, {(VW-1){1'b1}}} || res == {1'b1, {(VW-1){1'b0}}})
      else $error("saturated result not at a limit");

endmodule

bind clamped_barycentric_interp cbi_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_cbi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
